// File: rtl/cpeq_pkg.sv
// Shared types and constants for the coalescing port event queue.
// Used by every module in the rtl folder; depends on nothing.
package cpeq_pkg;

    // Build-time sizing.
    localparam int NUM_CONTROLLERS = 4;
    localparam int QUEUE_DEPTH     = 8;

    // Derived widths.
    localparam int CTRL_IDX_W = (NUM_CONTROLLERS > 1) ? $clog2(NUM_CONTROLLERS) : 1;
    localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int PORT_W     = 8;
    localparam int CTRL_W     = 3;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Controller count as seen by a comparison with the four-bit extended index.
    localparam logic [CTRL_W:0] CTRL_LIMIT = (CTRL_W + 1)'(NUM_CONTROLLERS);

    // Register word index for controllers_present.
    localparam logic REG_IDX_CTRL_PRESENT = 1'b0;

    // Command codes.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_POPPED   = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_BAD_CTRL = 2'd3
    } status_t;

    // Control for one cell in a queue chain.
    typedef struct packed {
        logic              shift;     // take the neighbour's entry (pop)
        logic              load;      // append the pushed notice here
        logic              upd;       // a push is under way: rewrite flag on match
        logic              occupied;  // this cell holds a live entry
        logic [PORT_W-1:0] port;      // pushed port
        logic              conn;      // pushed connected flag
    } cell_ctrl_t;

    // Operation presented to one controller's queue.
    typedef struct packed {
        logic              push;
        logic              pop;
        logic [PORT_W-1:0] port;
        logic              conn;
    } queue_op_t;

    // Status returned by one controller's queue.
    typedef struct packed {
        logic              ovf;
        logic              empty;
        logic [PORT_W-1:0] head_port;
        logic              head_conn;
    } queue_stat_t;

endpackage

// File: rtl/cpeq_cell.sv
// One entry cell of a queue chain: holds a port and its connected flag.
// Depends on cpeq_pkg.
module cpeq_cell (
    input  logic                          clk,
    input  cpeq_pkg::cell_ctrl_t          ctrl,
    input  logic [cpeq_pkg::PORT_W-1:0]   nb_port,
    input  logic                          nb_conn,
    output logic [cpeq_pkg::PORT_W-1:0]   port,
    output logic                          conn,
    output logic                          match
);
    import cpeq_pkg::*;

    logic [PORT_W-1:0] port_reg;
    logic [PORT_W-1:0] port_next;
    logic              conn_reg;
    logic              conn_next;

    // A live entry matches when it holds the pushed port.
    assign match = ctrl.occupied && (port_reg == ctrl.port);

    // Shift towards the head on a pop, load on an append, or rewrite the flag in place.
    always_comb
    begin
        port_next = port_reg;
        conn_next = conn_reg;
        if (ctrl.shift)
        begin
            port_next = nb_port;
            conn_next = nb_conn;
        end
        else if (ctrl.load)
        begin
            port_next = ctrl.port;
            conn_next = ctrl.conn;
        end
        else if (ctrl.upd && match)
        begin
            conn_next = ctrl.conn;
        end
    end

    // Entry storage carries no reset.
    always_ff @(posedge clk)
    begin
        port_reg <= port_next;
        conn_reg <= conn_next;
    end

    assign port = port_reg;
    assign conn = conn_reg;

endmodule

// File: rtl/cpeq_queue.sv
// One controller's coalescing queue: a chain of entry cells with the head at
// cell 0, a fill count and a sticky overflow mark. Depends on cpeq_pkg, cpeq_cell.
module cpeq_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cpeq_pkg::queue_op_t     op,
    output cpeq_pkg::queue_stat_t   stat
);
    import cpeq_pkg::*;

    logic [FILL_W-1:0]      fill_reg;
    logic [FILL_W-1:0]      fill_next;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic [QUEUE_DEPTH-1:0] match;
    logic [PORT_W-1:0]      cell_port [QUEUE_DEPTH];
    logic                   cell_conn [QUEUE_DEPTH];
    logic                   any_match;
    logic                   full;
    logic                   empty;
    logic                   do_append;
    logic                   do_shift;

    assign any_match = |match;
    assign full      = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign empty     = (fill_reg == '0);
    assign do_append = op.push && !any_match && !full;
    assign do_shift  = op.pop && !ovf_reg && !empty;

    // The chain of cells; on a pop each cell but the last takes its upper neighbour's entry.
    for (genvar k = 0; k < QUEUE_DEPTH; k++)
    begin : g_cell
        localparam logic [FILL_W-1:0] POS = FILL_W'(k);
        cell_ctrl_t        cc;
        logic [PORT_W-1:0] nb_port;
        logic              nb_conn;

        assign cc.shift    = do_shift;
        assign cc.load     = do_append && (fill_reg == POS);
        assign cc.upd      = op.push;
        assign cc.occupied = (POS < fill_reg);
        assign cc.port     = op.port;
        assign cc.conn     = op.conn;

        if (k == QUEUE_DEPTH - 1)
        begin : g_last
            assign nb_port = cell_port[k];
            assign nb_conn = cell_conn[k];
        end
        else
        begin : g_mid
            assign nb_port = cell_port[k+1];
            assign nb_conn = cell_conn[k+1];
        end

        cpeq_cell u_cell (
            .clk     (clk),
            .ctrl    (cc),
            .nb_port (nb_port),
            .nb_conn (nb_conn),
            .port    (cell_port[k]),
            .conn    (cell_conn[k]),
            .match   (match[k])
        );
    end

    // Fill count and overflow mark updates.
    always_comb
    begin
        fill_next = fill_reg;
        ovf_next  = ovf_reg;
        if (op.push)
        begin
            if (!any_match && full)
            begin
                ovf_next = 1'b1;
            end
            else if (do_append)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
        else if (op.pop)
        begin
            if (ovf_reg)
            begin
                ovf_next = 1'b0;
            end
            else if (!empty)
            begin
                fill_next = fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign stat.ovf       = ovf_reg;
    assign stat.empty     = empty;
    assign stat.head_port = cell_port[0];
    assign stat.head_conn = cell_conn[0];

endmodule

// File: rtl/coalescing_port_event_queue_top.sv
// Top level of the coalescing port event queue: command decode, the
// configuration register, one cell-chain queue per controller and the result register.
// Latency: the result of a pop is strobed on done in the cycle after the item is accepted.
// Throughput: one item per clock; busy stays low, as every queue matches all its cells
// in parallel and shifts its whole chain at once. The receiver cannot stall results.
// Reset clears fill counts, overflow marks and controllers_present; entry cells are not reset.
module coalescing_port_event_queue_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // Command channel
    input  logic                                start,
    output logic                                busy,
    input  logic                                cmd,
    input  logic [cpeq_pkg::CTRL_W-1:0]         controller,
    input  logic [cpeq_pkg::PORT_W-1:0]         port_in,
    input  logic                                connected_in,
    // Result channel
    output logic                                done,
    output logic [1:0]                          status,
    output logic [cpeq_pkg::PORT_W-1:0]         port_out,
    output logic                                connected_out,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cpeq_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cpeq_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cpeq_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import cpeq_pkg::*;

    logic [CTRL_W-1:0]     cp_reg;
    logic                  cfg_wr;
    logic                  accept;
    logic                  in_range;
    logic                  good_ctrl;
    logic [CTRL_IDX_W-1:0] sel;
    queue_op_t             qop  [NUM_CONTROLLERS];
    queue_stat_t           qst  [NUM_CONTROLLERS];
    queue_stat_t           cur;
    logic                  done_reg;
    logic                  done_next;
    status_t               status_reg;
    status_t               status_next;
    logic [PORT_W-1:0]     port_reg;
    logic [PORT_W-1:0]     port_next;
    logic                  conn_reg;
    logic                  conn_next;

    // Configuration register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_reg <= '0;
        end
        else if (cfg_wr && (paddr[2] == REG_IDX_CTRL_PRESENT))
        begin
            cp_reg <= pwdata[CTRL_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_IDX_CTRL_PRESENT)
                    ? {{(APB_DATA_W - CTRL_W){1'b0}}, cp_reg} : '0;

    // Command decode.
    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign in_range  = ({1'b0, controller} < CTRL_LIMIT);
    assign good_ctrl = in_range && (controller < cp_reg);
    assign sel       = controller[CTRL_IDX_W-1:0];

    // One queue per built controller.
    for (genvar c = 0; c < NUM_CONTROLLERS; c++)
    begin : g_queue
        localparam logic [CTRL_IDX_W-1:0] ID = CTRL_IDX_W'(c);

        assign qop[c].push = accept && (cmd == CMD_PUSH) && in_range && (sel == ID)
                             && (port_in != '0);
        assign qop[c].pop  = accept && (cmd == CMD_POP) && good_ctrl && (sel == ID);
        assign qop[c].port = port_in;
        assign qop[c].conn = connected_in;

        cpeq_queue u_queue (
            .clk   (clk),
            .rst_n (rst_n),
            .op    (qop[c]),
            .stat  (qst[c])
        );
    end

    // Status of the addressed queue; only used when the controller is in range.
    assign cur = qst[sel];

    // Result formation for a pop.
    always_comb
    begin
        done_next   = accept && (cmd == CMD_POP);
        status_next = ST_BAD_CTRL;
        port_next   = '0;
        conn_next   = 1'b0;
        if (!good_ctrl)
        begin
            status_next = ST_BAD_CTRL;
        end
        else if (cur.ovf)
        begin
            status_next = ST_OVERFLOW;
        end
        else if (cur.empty)
        begin
            status_next = ST_EMPTY;
        end
        else
        begin
            status_next = ST_POPPED;
            port_next   = cur.head_port;
            conn_next   = cur.head_conn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            status_reg <= status_next;
            port_reg   <= port_next;
            conn_reg   <= conn_next;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign port_out      = port_reg;
    assign connected_out = conn_reg;

    // A result appears only in the cycle after an accepted pop.
    a_done_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && (cmd == CMD_POP)))
        else $error("result strobe without an accepted pop");

    // Anything but a popped entry carries a zero payload.
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_POPPED)) |-> ((port_out == '0) && !connected_out))
        else $error("payload not zero on a non-entry result");

    // A pop to an unknown or absent controller reports a bad controller.
    a_bad_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == CMD_POP) && !good_ctrl) |=> (done && (status == ST_BAD_CTRL)))
        else $error("bad controller not reported");

endmodule
